@@ rtl/hsw_pkg.sv @@
// Shared types and codes for the heartbeat stall watchdog.
package hsw_pkg;

    // Event kinds carried on the request channel.
    localparam logic [2:0] FUNC_START     = 3'd0;
    localparam logic [2:0] FUNC_HEARTBEAT = 3'd1;
    localparam logic [2:0] FUNC_PAUSE     = 3'd2;
    localparam logic [2:0] FUNC_RESUME    = 3'd3;
    localparam logic [2:0] FUNC_POLL      = 3'd4;
    localparam logic [2:0] FUNC_STOP      = 3'd5;

    // Result codes.
    localparam logic [1:0] RES_NONE    = 2'd0;
    localparam logic [1:0] RES_HANG    = 2'd1;
    localparam logic [1:0] RES_RECOVER = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_THRESHOLD     = 1'b0;
    localparam logic CFG_POLL_INTERVAL = 1'b1;

    // Reset values and limits.
    localparam logic [15:0] THRESHOLD_RESET     = 16'd5000;
    localparam logic [15:0] POLL_INTERVAL_RESET = 16'd500;
    localparam logic [15:0] DEFAULT_THRESHOLD   = 16'd5000;
    localparam logic [15:0] PAUSE_DEPTH_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now_ms;
        logic        record_gap;
        logic        suppress;
        logic        reporting_enabled;
    } hsw_req_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] stalled_ms;
        logic [15:0] report_number;
        logic [31:0] worst_gap_ms;
        logic [15:0] pauses_taken;
    } hsw_res_t;

    typedef struct packed {
        logic [15:0] threshold_ms;
        logic [15:0] poll_interval_ms;
    } hsw_cfg_t;

endpackage

@@ rtl/heartbeat_stall_watchdog.sv @@
// Top level of the heartbeat stall watchdog: stream ports, configuration and staging.
//
// Each request on the s_ channel is one timestamped event (start, heartbeat,
// pause, resume, poll or stop); the kind travels on s_tuser. Every request
// yields exactly one result on the m_ channel, in order: a result code on
// m_tuser (nothing, hang reported, recovered) plus the stall length, report
// count, worst heartbeat gap and pause total on m_tdata.
//
// A request is held in an input register and applied to the watchdog state
// in the cycle it leaves that register; the result lands in an output
// register. One request per cycle is sustained while m_tready stays high.
// While a result waits on m_tready, one further request is still taken and
// parked in the input register; s_tready drops only when both are full.
//
// The threshold and poll interval registers are written through cfg_wr_en, cfg_addr
// and cfg_wdata; the user writes them only while no request is in flight (not enforced). Reset (aresetn low,
// synchronous) empties both stages, clears the watchdog state and restores
// the register defaults of 5000 ms and 500 ms.
module heartbeat_stall_watchdog
    import hsw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms[31:0], record_gap[32], suppress[33], reporting_enabled[34], zero pad
    input  logic [39:0] s_tdata,
    // func[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // stalled_ms[31:0], report_number[47:32], worst_gap_ms[79:48], pauses_taken[95:80]
    output logic [95:0] m_tdata,
    // event_res[1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic     in_valid_reg;
    hsw_req_t in_req_reg;
    logic     out_valid_reg;
    hsw_res_t out_res_reg;
    hsw_cfg_t cfg_reg;
    hsw_req_t s_req;
    hsw_res_t core_res;
    logic     fire;
    logic     s_accept;

    // Unpack the request.
    assign s_req.func              = s_tuser;
    assign s_req.now_ms            = s_tdata[31:0];
    assign s_req.record_gap        = s_tdata[32];
    assign s_req.suppress          = s_tdata[33];
    assign s_req.reporting_enabled = s_tdata[34];

    // Handshake: process when the output stage is free or being drained.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_ms     <= THRESHOLD_RESET;
            cfg_reg.poll_interval_ms <= POLL_INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_THRESHOLD:     cfg_reg.threshold_ms     <= cfg_wdata;
                CFG_POLL_INTERVAL: cfg_reg.poll_interval_ms <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_req_reg <= s_req;
        end
    end

    hsw_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .req     (in_req_reg),
        .cfg     (cfg_reg),
        .res     (core_res)
    );

    // Output stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= core_res;
        end
    end

    // Pack the result.
    assign m_tvalid       = out_valid_reg;
    assign m_tuser        = out_res_reg.event_res;
    assign m_tdata[31:0]  = out_res_reg.stalled_ms;
    assign m_tdata[47:32] = out_res_reg.report_number;
    assign m_tdata[79:48] = out_res_reg.worst_gap_ms;
    assign m_tdata[95:80] = out_res_reg.pauses_taken;

endmodule

@@ rtl/hsw_core.sv @@
// Watchdog state and the update that each processed request applies to it.
module hsw_core
    import hsw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     fire,
    input  hsw_req_t req,
    input  hsw_cfg_t cfg,
    output hsw_res_t res
);

    logic        running_reg, running_next;
    logic [31:0] last_beat_reg, last_beat_next;
    logic [31:0] last_poll_reg, last_poll_next;
    logic [31:0] worst_gap_reg, worst_gap_next;
    logic [15:0] pause_depth_reg, pause_depth_next;
    logic [15:0] pause_total_reg, pause_total_next;
    logic        skip_gap_reg, skip_gap_next;
    logic        hang_reg, hang_next;
    logic [15:0] report_count_reg, report_count_next;
    logic        beat_valid_reg, beat_valid_next;

    logic [15:0] thr_eff;
    logic [16:0] poll_limit;
    logic [31:0] beat_gap;
    logic [31:0] poll_gap;
    logic [31:0] stalled;
    logic [1:0]  event_res;
    logic [31:0] stalled_out;

    // Effective threshold, poll limit and the differences used by the heartbeat and poll paths.
    assign thr_eff    = (cfg.threshold_ms == 16'd0) ? DEFAULT_THRESHOLD : cfg.threshold_ms;
    assign poll_limit = {1'b0, cfg.poll_interval_ms} + {1'b0, thr_eff};
    assign beat_gap   = req.now_ms - last_beat_reg;
    assign poll_gap   = req.now_ms - last_poll_reg;
    assign stalled    = req.now_ms - last_beat_reg;

    // Next state and result for the request being processed.
    always_comb begin
        running_next      = running_reg;
        last_beat_next    = last_beat_reg;
        last_poll_next    = last_poll_reg;
        worst_gap_next    = worst_gap_reg;
        pause_depth_next  = pause_depth_reg;
        pause_total_next  = pause_total_reg;
        skip_gap_next     = skip_gap_reg;
        hang_next         = hang_reg;
        report_count_next = report_count_reg;
        beat_valid_next   = beat_valid_reg;
        event_res         = RES_NONE;
        stalled_out       = 32'd0;

        unique case (req.func)
            FUNC_START: begin
                if (!running_reg) begin
                    last_beat_next    = req.now_ms;
                    beat_valid_next   = 1'b1;
                    worst_gap_next    = 32'd0;
                    pause_depth_next  = 16'd0;
                    hang_next         = 1'b0;
                    report_count_next = 16'd0;
                    skip_gap_next     = 1'b1;
                    last_poll_next    = req.now_ms;
                    running_next      = 1'b1;
                end
            end
            FUNC_HEARTBEAT: begin
                last_beat_next  = req.now_ms;
                beat_valid_next = 1'b1;
                skip_gap_next   = 1'b0;
                if (req.record_gap && !skip_gap_reg && beat_valid_reg &&
                    (beat_gap > worst_gap_reg)) begin
                    worst_gap_next = beat_gap;
                end
            end
            FUNC_PAUSE: begin
                pause_total_next = pause_total_reg + 16'd1;
                if (pause_depth_reg != PAUSE_DEPTH_MAX) begin
                    pause_depth_next = pause_depth_reg + 16'd1;
                end
            end
            FUNC_RESUME: begin
                if (pause_depth_reg != 16'd0) begin
                    pause_depth_next = pause_depth_reg - 16'd1;
                end
                // The last pause released (or none held): restart the beat clock.
                if (pause_depth_reg <= 16'd1) begin
                    last_beat_next  = req.now_ms;
                    beat_valid_next = 1'b1;
                    skip_gap_next   = 1'b1;
                end
            end
            FUNC_POLL: begin
                if (running_reg) begin
                    last_poll_next = req.now_ms;
                    if (poll_gap > {15'd0, poll_limit}) begin
                        // The poller itself was frozen: re-arm quietly.
                        last_beat_next = req.now_ms;
                    end else if (pause_depth_reg != 16'd0) begin
                        last_beat_next = req.now_ms;
                    end else if (stalled < {16'd0, thr_eff}) begin
                        if (hang_reg) begin
                            hang_next = 1'b0;
                            event_res = RES_RECOVER;
                        end
                    end else if (!hang_reg && !req.suppress) begin
                        hang_next = 1'b1;
                        if (req.reporting_enabled) begin
                            report_count_next = report_count_reg + 16'd1;
                            stalled_out       = stalled;
                            event_res         = RES_HANG;
                        end
                    end
                end
            end
            FUNC_STOP: begin
                running_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // State registers advance once per processed request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg      <= 1'b0;
            last_beat_reg    <= 32'd0;
            last_poll_reg    <= 32'd0;
            worst_gap_reg    <= 32'd0;
            pause_depth_reg  <= 16'd0;
            pause_total_reg  <= 16'd0;
            skip_gap_reg     <= 1'b0;
            hang_reg         <= 1'b0;
            report_count_reg <= 16'd0;
            beat_valid_reg   <= 1'b0;
        end else if (fire) begin
            running_reg      <= running_next;
            last_beat_reg    <= last_beat_next;
            last_poll_reg    <= last_poll_next;
            worst_gap_reg    <= worst_gap_next;
            pause_depth_reg  <= pause_depth_next;
            pause_total_reg  <= pause_total_next;
            skip_gap_reg     <= skip_gap_next;
            hang_reg         <= hang_next;
            report_count_reg <= report_count_next;
            beat_valid_reg   <= beat_valid_next;
        end
    end

    // Result fields reflect the state after this request.
    assign res.event_res     = event_res;
    assign res.stalled_ms    = stalled_out;
    assign res.report_number = report_count_next;
    assign res.worst_gap_ms  = worst_gap_next;
    assign res.pauses_taken  = pause_total_next;

    // A reported hang leaves the hang latched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (event_res == RES_HANG) |=> hang_reg)
        else $error("hang reported but not latched");

    // A recovery clears the latch.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (event_res == RES_RECOVER) |=> !hang_reg)
        else $error("recovery left the hang latched");

    // The report count moves only on a report or a fresh start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (event_res != RES_HANG) && (req.func != FUNC_START)
        |=> report_count_reg == $past(report_count_reg))
        else $error("report count changed without a report");

    // A stall length is given only with a hang report.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (event_res != RES_HANG) |-> (stalled_out == 32'd0))
        else $error("stall length given without a report");

    // Every pause request bumps the pause total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (req.func == FUNC_PAUSE)
        |=> pause_total_reg == $past(pause_total_reg) + 16'd1)
        else $error("pause total not advanced");

endmodule

@@ sim/tb_heartbeat_stall_watchdog.sv @@
// Self-checking testbench for the heartbeat stall watchdog, with a scoreboard that predicts every result.
`timescale 1ns / 100ps

import hsw_pkg::*;

// Mirror of the watchdog state. It predicts the result of each accepted request
// and checks results in order as they leave the block.
class watchdog_scoreboard;
    bit [15:0]   threshold;
    bit [15:0]   poll_interval;
    bit          running;
    bit [31:0]   beat_ms;
    bit [31:0]   poll_ms;
    bit [31:0]   worst_gap;
    bit [15:0]   pause_depth;
    bit [15:0]   pause_total;
    bit [15:0]   reports;
    bit          skip_gap;
    bit          hang_latched;
    bit          beat_known;
    hsw_res_t    expected_results[$];
    int unsigned mismatches;

    function new();
        threshold     = THRESHOLD_RESET;
        poll_interval = POLL_INTERVAL_RESET;
    endfunction

    function void set_config(logic addr, bit [15:0] value);
        if (addr == CFG_THRESHOLD) begin
            threshold = value;
        end else begin
            poll_interval = value;
        end
    endfunction

    // A zero threshold falls back to the default.
    function bit [31:0] eff_threshold();
        return (threshold == 0) ? 32'(DEFAULT_THRESHOLD) : 32'(threshold);
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction

    // Poll decision: frozen-machine re-arm, pause hold-off, recovery or hang.
    function bit [1:0] predict_poll(bit [31:0] now, bit sup, bit rep, output bit [31:0] stall_len);
        bit [31:0] thr;
        bit [31:0] since_poll;
        bit [31:0] idle;
        thr       = eff_threshold();
        stall_len = '0;
        if (!running) return RES_NONE;
        since_poll = now - poll_ms;
        poll_ms    = now;
        if (since_poll > thr + poll_interval) begin
            beat_ms = now;
            return RES_NONE;
        end
        if (pause_depth != 0) begin
            beat_ms = now;
            return RES_NONE;
        end
        idle = now - beat_ms;
        if (idle < thr) begin
            if (hang_latched) begin
                hang_latched = 1'b0;
                return RES_RECOVER;
            end
            return RES_NONE;
        end
        if (hang_latched || sup) return RES_NONE;
        hang_latched = 1'b1;
        if (!rep) return RES_NONE;
        reports++;
        stall_len = idle;
        return RES_HANG;
    endfunction

    // Applies one accepted request and queues the result it must produce.
    function void predict_event(hsw_req_t r);
        hsw_res_t  res;
        bit [31:0] gap;
        bit [31:0] stall_len;
        res = '0;
        case (r.func)
            FUNC_START: begin
                if (!running) begin
                    beat_ms      = r.now_ms;
                    beat_known   = 1'b1;
                    worst_gap    = '0;
                    pause_depth  = '0;
                    hang_latched = 1'b0;
                    reports      = '0;
                    skip_gap     = 1'b1;
                    poll_ms      = r.now_ms;
                    running      = 1'b1;
                end
            end
            FUNC_HEARTBEAT: begin
                if (r.record_gap && !skip_gap && beat_known) begin
                    gap = r.now_ms - beat_ms;
                    if (gap > worst_gap) worst_gap = gap;
                end
                beat_ms    = r.now_ms;
                beat_known = 1'b1;
                skip_gap   = 1'b0;
            end
            FUNC_PAUSE: begin
                pause_total++;
                if (pause_depth != PAUSE_DEPTH_MAX) pause_depth++;
            end
            FUNC_RESUME: begin
                // The last resume, or one without a pause, restarts the beat clock.
                if (pause_depth <= 1) begin
                    beat_ms    = r.now_ms;
                    beat_known = 1'b1;
                    skip_gap   = 1'b1;
                end
                if (pause_depth != 0) pause_depth--;
            end
            FUNC_POLL: begin
                res.event_res  = predict_poll(r.now_ms, r.suppress, r.reporting_enabled,
                                              stall_len);
                res.stalled_ms = stall_len;
            end
            FUNC_STOP: begin
                running = 1'b0;
            end
            default: begin
            end
        endcase
        res.report_number = reports;
        res.worst_gap_ms  = worst_gap;
        res.pauses_taken  = pause_total;
        expected_results = {expected_results, res};
    endfunction

    function void compare(string field, bit [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(hsw_res_t got);
        hsw_res_t want;
        if (expected_results.size() == 0) begin
            $error("result arrived with no request outstanding");
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        compare("event_res", 32'(want.event_res), 32'(got.event_res));
        compare("stalled_ms", want.stalled_ms, got.stalled_ms);
        compare("report_number", 32'(want.report_number), 32'(got.report_number));
        compare("worst_gap_ms", want.worst_gap_ms, got.worst_gap_ms);
        compare("pauses_taken", 32'(want.pauses_taken), 32'(got.pauses_taken));
    endfunction
endclass

module tb_heartbeat_stall_watchdog;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam logic [2:0]  FUNC_SPARE6 = 3'd6;
    localparam logic [2:0]  FUNC_SPARE7 = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;

    watchdog_scoreboard board = new();
    hsw_res_t           seen_result;
    bit [31:0]          clock_ms;
    int unsigned        idle_pct;
    int unsigned        stall_pct;
    int unsigned        quiet_cycles;

    heartbeat_stall_watchdog dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    assign seen_result = {m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[79:48],
                          m_tdata[95:80]};

    // Result checking and the no-progress watchdog.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(seen_result);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[heartbeat_stall_watchdog] ERROR");
            $finish;
        end
    end

    function automatic bit chance(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Receiver back-pressure in random bursts.
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (chance(stall_pct)) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
                m_tready = 1'b1;
            end
        end
    end

    // Presents one request, waits for it to be taken, and records it.
    // Called and returns at a falling edge.
    task automatic send_req(logic [2:0] func, bit [31:0] now, bit rec, bit sup, bit rep);
        hsw_req_t r;
        r.func              = func;
        r.now_ms            = now;
        r.record_gap        = rec;
        r.suppress          = sup;
        r.reporting_enabled = rep;
        if (chance(idle_pct)) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, rep, sup, rec, now};
        s_tuser  = func;
        do @(posedge aclk); while (!s_tready);
        board.predict_event(r);
        @(negedge aclk);
    endtask

    // Stops sending and waits until every outstanding result has come back.
    task automatic settle();
        s_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_cfg(logic addr, bit [15:0] value);
        cfg_wr_en = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        board.set_config(addr, value);
    endtask

    // Random traffic built from segments: busy activity, stalls, paused
    // stretches, start/stop churn, frozen pollers and raw noise.
    task automatic run_random(int unsigned count);
        int unsigned issued;
        int unsigned seg_len;
        int unsigned kind;
        int unsigned pick;
        bit [31:0]   thr;
        bit [31:0]   span;
        bit [31:0]   now_val;
        logic [2:0]  func;
        issued = 0;
        while (issued < count) begin
            thr     = board.eff_threshold();
            span    = thr + board.poll_interval;
            seg_len = $urandom_range(3, 20);
            kind    = $urandom_range(0, 99);
            if ($urandom_range(0, 29) == 0) begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, span * 4);
            end
            if (!board.running && chance(80)) begin
                clock_ms += $urandom_range(0, thr);
                send_req(FUNC_START, clock_ms, chance(70), chance(20), chance(80));
                issued++;
            end
            for (int unsigned k = 0; k < seg_len; k++) begin
                pick = $urandom_range(0, 19);
                if (kind < 40) begin
                    clock_ms += $urandom_range(0, thr / 4 + 1);
                    func = (pick < 8) ? FUNC_HEARTBEAT : (pick < 17) ? FUNC_POLL :
                           (pick < 19) ? FUNC_PAUSE : FUNC_RESUME;
                end else if (kind < 65) begin
                    // Polls keep their cadence while beats are mostly missing.
                    clock_ms += $urandom_range(thr / 4 + 1, span);
                    func = (pick < 2) ? FUNC_HEARTBEAT : FUNC_POLL;
                end else if (kind < 75) begin
                    clock_ms += $urandom_range(1, span);
                    if (k == 0) begin
                        func = FUNC_PAUSE;
                    end else if (k == seg_len - 1) begin
                        func = FUNC_RESUME;
                    end else begin
                        func = (pick < 2) ? FUNC_PAUSE : (pick < 4) ? FUNC_RESUME :
                               (pick < 7) ? FUNC_HEARTBEAT : FUNC_POLL;
                    end
                end else if (kind < 82) begin
                    clock_ms += $urandom_range(0, thr);
                    func = (pick < 5) ? FUNC_START : (pick < 9) ? FUNC_STOP :
                           (pick < 14) ? FUNC_HEARTBEAT : FUNC_POLL;
                end else if (kind < 90) begin
                    // The poller itself falls further behind than allowed.
                    clock_ms += span + $urandom_range(1, thr * 2 + 1);
                    func = (pick < 4) ? FUNC_HEARTBEAT : FUNC_POLL;
                end else begin
                    func = 3'($urandom_range(0, 7));
                end
                now_val = clock_ms;
                if (kind >= 90) begin
                    now_val = $urandom;
                    if (chance(25)) clock_ms = now_val;
                end
                send_req(func, now_val, chance(70), chance(20), chance(80));
                issued++;
            end
        end
    endtask

    task automatic run_phase(bit [15:0] thr, bit [15:0] interval, int unsigned count,
                             int unsigned pressure);
        settle();
        write_cfg(CFG_THRESHOLD, thr);
        write_cfg(CFG_POLL_INTERVAL, interval);
        idle_pct  = pressure;
        stall_pct = pressure / 2;
        run_random(count);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = 1'b0;
        cfg_wdata = '0;
        idle_pct  = 10;
        stall_pct = 5;
        clock_ms  = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed events under the reset register values.
        send_req(FUNC_POLL, 32'd0, 1'b1, 1'b0, 1'b1);          // poll while stopped
        send_req(FUNC_HEARTBEAT, 32'd100, 1'b1, 1'b0, 1'b0);   // beat before any start
        send_req(FUNC_PAUSE, 32'd150, 1'b0, 1'b1, 1'b1);       // pause while stopped
        send_req(FUNC_RESUME, 32'd200, 1'b0, 1'b0, 1'b0);
        send_req(FUNC_RESUME, 32'd250, 1'b1, 1'b1, 1'b1);      // resume with no pause
        send_req(FUNC_START, 32'd1000, 1'b0, 1'b0, 1'b1);
        send_req(FUNC_START, 32'd1100, 1'b1, 1'b1, 1'b1);      // start while running
        send_req(FUNC_HEARTBEAT, 32'd1200, 1'b1, 1'b0, 1'b1);  // first gap is skipped
        send_req(FUNC_HEARTBEAT, 32'd1500, 1'b1, 1'b0, 1'b1);
        send_req(FUNC_HEARTBEAT, 32'd1600, 1'b0, 1'b0, 1'b1);
        send_req(FUNC_POLL, 32'd4000, 1'b0, 1'b0, 1'b1);
        send_req(FUNC_POLL, 32'd6700, 1'b0, 1'b0, 1'b0);       // hang, reporting off
        send_req(FUNC_HEARTBEAT, 32'd6800, 1'b1, 1'b0, 1'b1);
        send_req(FUNC_POLL, 32'd6900, 1'b0, 1'b0, 1'b1);       // recovery
        send_req(FUNC_POLL, 32'd12000, 1'b0, 1'b1, 1'b1);      // excused stall
        send_req(FUNC_POLL, 32'd12100, 1'b0, 1'b0, 1'b1);      // reported hang
        send_req(FUNC_POLL, 32'd12200, 1'b0, 1'b0, 1'b1);      // still latched
        send_req(FUNC_POLL, 32'd20000, 1'b0, 1'b0, 1'b1);      // poller froze
        send_req(FUNC_PAUSE, 32'd20100, 1'b0, 1'b0, 1'b1);
        send_req(FUNC_PAUSE, 32'd20200, 1'b0, 1'b0, 1'b1);
        send_req(FUNC_POLL, 32'd27000, 1'b0, 1'b0, 1'b1);      // poller froze again while paused
        send_req(FUNC_RESUME, 32'd27100, 1'b0, 1'b0, 1'b1);
        send_req(FUNC_RESUME, 32'd27200, 1'b1, 1'b0, 1'b1);
        send_req(FUNC_SPARE6, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        send_req(FUNC_SPARE7, 32'h5555_AAAA, 1'b0, 1'b0, 1'b0);
        send_req(FUNC_HEARTBEAT, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
        send_req(FUNC_HEARTBEAT, 32'd5, 1'b1, 1'b0, 1'b1);     // gap across the wrap
        send_req(FUNC_STOP, 32'd10, 1'b0, 1'b0, 1'b1);
        clock_ms = 32'd100;

        // Random phases over several register settings.
        run_phase($urandom_range(1, 2000), $urandom_range(1, 2000), 200, 15);
        run_phase(16'd0, 16'hFFFF, 200, 10);
        run_phase(16'd1, 16'd1, 200, 20);
        run_phase(16'hFFFF, 16'hFFFF, 200, 10);

        // Deep pause nesting that a single resume does not release.
        settle();
        idle_pct  = 0;
        stall_pct = 0;
        send_req(FUNC_STOP, clock_ms, 1'b0, 1'b0, 1'b1);
        send_req(FUNC_START, clock_ms, 1'b0, 1'b0, 1'b1);
        repeat (20) send_req(FUNC_PAUSE, clock_ms, 1'b0, 1'b0, 1'b1);
        send_req(FUNC_RESUME, clock_ms + 1, 1'b0, 1'b0, 1'b1);
        send_req(FUNC_POLL, clock_ms + 2, 1'b0, 1'b0, 1'b1);
        send_req(FUNC_STOP, clock_ms + 3, 1'b0, 1'b0, 1'b1);

        run_phase(16'd1, 16'hFFFF, 200, 10);

        // Repeated reports: beat, recover, then hang again, over and over.
        settle();
        idle_pct  = 0;
        stall_pct = 0;
        send_req(FUNC_STOP, clock_ms, 1'b0, 1'b0, 1'b1);
        send_req(FUNC_START, clock_ms, 1'b0, 1'b0, 1'b1);
        repeat (10) begin
            send_req(FUNC_HEARTBEAT, clock_ms, 1'b1, 1'b0, 1'b1);
            send_req(FUNC_POLL, clock_ms, 1'b0, 1'b0, 1'b1);
            clock_ms++;
            send_req(FUNC_POLL, clock_ms, 1'b0, 1'b0, 1'b1);
            clock_ms++;
        end

        run_phase(16'hFFFF, 16'd1, 200, 10);
        // Final stretch runs at full rate on both sides.
        run_phase(16'd40, 16'd25, 210, 0);

        settle();
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("[heartbeat_stall_watchdog] OK");
        end else begin
            $display("[heartbeat_stall_watchdog] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/hsw_pkg.sv
rtl/hsw_core.sv
rtl/heartbeat_stall_watchdog.sv
sim/tb_heartbeat_stall_watchdog.sv
